// ===== rtl/core/spvg_pkg.sv =====
package spvg_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_PINS  = 2'd3;

    localparam logic [7:0] LINE_CLOCKS     = 8'd228;
    localparam logic [7:0] HBLANK_END      = 8'd68;
    localparam logic [7:0] LONG_HBLANK_END = 8'd76;
    localparam logic [7:0] LINE_CENTER     = 8'd148;
    localparam logic [7:0] VISIBLE         = 8'd160;
    localparam logic [7:0] RELEASE_CLOCK   = 8'd3;

    localparam int OBJ_P0 = 0;
    localparam int OBJ_P1 = 1;
    localparam int OBJ_M0 = 2;
    localparam int OBJ_M1 = 3;
    localparam int OBJ_BL = 4;
    localparam int PIX_PF = 5;

    localparam int OF_ENAM0 = 0;
    localparam int OF_ENABL_NEW = 2;
    localparam int OF_ENABL_OLD = 3;
    localparam int OF_REFP0 = 4;
    localparam int OF_VDELP0 = 6;
    localparam int OF_VDELBL = 8;
    localparam int OF_RESMP0 = 9;

    localparam logic [5:0] A_VSYNC = 6'h00, A_VBLANK = 6'h01, A_WSYNC = 6'h02,
        A_RSYNC = 6'h03, A_NUSIZ0 = 6'h04, A_NUSIZ1 = 6'h05, A_COLUP0 = 6'h06,
        A_COLUP1 = 6'h07, A_COLUPF = 6'h08, A_COLUBK = 6'h09, A_CTRLPF = 6'h0a,
        A_REFP0 = 6'h0b, A_REFP1 = 6'h0c, A_PF0 = 6'h0d, A_PF1 = 6'h0e, A_PF2 = 6'h0f,
        A_RESP0 = 6'h10, A_RESP1 = 6'h11, A_RESM0 = 6'h12, A_RESM1 = 6'h13,
        A_RESBL = 6'h14, A_GRP0 = 6'h1b, A_GRP1 = 6'h1c, A_ENAM0 = 6'h1d,
        A_ENAM1 = 6'h1e, A_ENABL = 6'h1f, A_HMP0 = 6'h20, A_HMP1 = 6'h21,
        A_HMM0 = 6'h22, A_HMM1 = 6'h23, A_HMBL = 6'h24, A_VDELP0 = 6'h25,
        A_VDELP1 = 6'h26, A_VDELBL = 6'h27, A_RESMP0 = 6'h28, A_RESMP1 = 6'h29,
        A_HMOVE = 6'h2a, A_HMCLR = 6'h2b, A_CXCLR = 6'h2c;

    localparam int PAIR_A [15] = '{OBJ_M0, OBJ_M0, OBJ_M1, OBJ_M1, OBJ_P0, OBJ_P0, OBJ_P1,
        OBJ_P1, OBJ_M0, OBJ_M0, OBJ_M1, OBJ_M1, OBJ_BL, OBJ_P0, OBJ_M0};
    localparam int PAIR_B [15] = '{OBJ_P1, OBJ_P0, OBJ_P0, OBJ_P1, PIX_PF, OBJ_BL, PIX_PF,
        OBJ_BL, PIX_PF, OBJ_BL, PIX_PF, OBJ_BL, PIX_PF, OBJ_P1, OBJ_M1};

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] address;
        logic [7:0] data;
        logic [5:0] pins_set;
        logic [5:0] pins_cleared;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pixel_valid;
        logic [7:0] pixel_column;
        logic [7:0] pixel_color;
        logic       line_end;
        logic       line_shown;
        logic       frame_start;
        logic       cpu_hold;
        logic       cpu_release;
        logic       pots_dumped;
    } out_item_t;

    function automatic logic copy_start(input logic [7:0] ctr, input logic [7:0] nus);
        logic [2:0] n;
        logic r;
        n = nus[2:0];
        r = 1'b0;
        if (ctr == 8'd0) r = 1'b1;
        else if (ctr == 8'd16) r = (n == 3'd1) || (n == 3'd3);
        else if (ctr == 8'd32) r = (n == 3'd2) || (n == 3'd3) || (n == 3'd6);
        else if (ctr == 8'd64) r = (n == 3'd4) || (n == 3'd6);
        return r;
    endfunction

endpackage

// ===== rtl/core/spvg_stream_if.sv =====
interface spvg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sprite_playfield_video_generator.sv =====
// Channel   Direction  Payload
// in_ch     sink       operation, address, data, pins_set, pins_cleared
// out_ch    source     read_data, pixel fields, line and processor flags
//
// Every item is finished in the cycle it is accepted; its result sits in one output
// register, so one item per cycle is sustained while the output is taken.
// A new item is accepted whenever the output register is empty or is read out in the
// same cycle. The asynchronous reset initializes every register except out_reg.
// A stalled output holds the result and blocks further input until it is taken.
module sprite_playfield_video_generator (
    input logic        clk,
    input logic        rst_n,
    spvg_stream_if.sink   in_ch,
    spvg_stream_if.source out_ch
);

    logic [7:0]  line_clock_reg, line_clock_next;
    logic [3:0]  blank_flags_reg, blank_flags_next;
    logic [7:0]  vblank_bits_reg, vblank_bits_next;
    logic [7:0]  pf_bits_reg [3], pf_bits_next [3];
    logic [7:0]  pf_shift_reg [3], pf_shift_next [3];
    logic [7:0]  mode_reg [3], mode_next [3];
    logic [7:0]  color_reg [4], color_next [4];
    logic [7:0]  grp_reg [4], grp_next [4];
    logic [11:0] oflags_reg, oflags_next;
    logic [3:0]  motion_reg [5], motion_next [5];
    logic [7:0]  pos_reg [5], pos_next [5];
    logic [5:0]  wid_reg [5], wid_next [5];
    logic [2:0]  rdel_reg [5], rdel_next [5];
    logic [4:0]  xclk_reg, xclk_next;
    logic [6:0]  mseq_reg, mseq_next;
    logic [5:0]  opix_reg, opix_next;
    logic [14:0] coll_reg, coll_next;
    logic [5:0]  pins_reg, pins_next;
    logic [1:0]  ilatch_reg, ilatch_next;
    logic        out_valid_reg;
    spvg_pkg::out_item_t out_reg, out_next;

    logic accept;
    spvg_pkg::in_item_t it;

    assign it = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    always_comb
    begin
        logic [7:0] hc, sx, p0, p1, p2, r0, c, at;
        logic [5:0] cnt, lim, sz;
        logic [2:0] mode, n, rr;
        logic [4:0] xc;
        logic refl, pfon, en, clk5 [5], shown, wide;
        line_clock_next = line_clock_reg;
        blank_flags_next = blank_flags_reg;
        vblank_bits_next = vblank_bits_reg;
        pf_bits_next = pf_bits_reg;
        pf_shift_next = pf_shift_reg;
        mode_next = mode_reg;
        color_next = color_reg;
        grp_next = grp_reg;
        oflags_next = oflags_reg;
        motion_next = motion_reg;
        pos_next = pos_reg;
        wid_next = wid_reg;
        rdel_next = rdel_reg;
        xclk_next = xclk_reg;
        mseq_next = mseq_reg;
        opix_next = opix_reg;
        coll_next = coll_reg;
        pins_next = pins_reg;
        ilatch_next = ilatch_reg;
        out_next = '0;
        hc = line_clock_reg;
        sx = '0; p0 = '0; p1 = '0; p2 = '0; r0 = '0; c = '0; at = '0;
        cnt = '0; lim = '0; sz = '0; mode = '0; n = '0; rr = '0; xc = '0;
        refl = 1'b0; pfon = 1'b0; en = 1'b0; shown = 1'b0; wide = 1'b0;
        for (int i = 0; i < 5; i++) clk5[i] = 1'b0;
        unique case (it.operation)
            spvg_pkg::OP_TICK:
            begin
                refl = mode_reg[0][0];
                p0 = pf_shift_reg[0]; p1 = pf_shift_reg[1]; p2 = pf_shift_reg[2];
                if (hc == spvg_pkg::HBLANK_END || (hc == spvg_pkg::LINE_CENTER && !refl))
                begin
                    p0 = 8'h10; p1 = '0; p2 = '0;
                end
                else if (hc == spvg_pkg::LINE_CENTER)
                begin
                    p0 = '0; p1 = '0; p2 = 8'h80;
                end
                opix_next[spvg_pkg::PIX_PF] = |((pf_bits_reg[0] & p0)
                                                | (pf_bits_reg[1] & p1)
                                                | (pf_bits_reg[2] & p2));
                if (hc[1:0] == 2'b11)
                begin
                    if (refl && hc >= spvg_pkg::LINE_CENTER)
                    begin
                        pf_shift_next[0] = (p0 >> 1) | (p1 & 8'h80);
                        pf_shift_next[1] = (p1 << 1) | (p2 & 8'h01);
                        pf_shift_next[2] = p2 >> 1;
                    end
                    else
                    begin
                        pf_shift_next[2] = (p2 << 1) | (p1 & 8'h01);
                        pf_shift_next[1] = (p1 >> 1) | (p0 & 8'h80);
                        pf_shift_next[0] = p0 << 1;
                    end
                end
                else
                begin
                    pf_shift_next[0] = p0; pf_shift_next[1] = p1; pf_shift_next[2] = p2;
                end
                for (int i = 0; i < 5; i++)
                    clk5[i] = !blank_flags_reg[0] || (xclk_reg[i] && mseq_reg[1:0] == 2'b00);

                // Ball.
                sz = 6'd1 << mode_reg[0][5:4];
                if (clk5[spvg_pkg::OBJ_BL] && wid_reg[spvg_pkg::OBJ_BL] != 0)
                begin
                    if (wid_reg[spvg_pkg::OBJ_BL] == sz)
                    begin
                        opix_next[spvg_pkg::OBJ_BL] = 1'b0; wid_next[spvg_pkg::OBJ_BL] = '0;
                    end
                    else wid_next[spvg_pkg::OBJ_BL] = wid_reg[spvg_pkg::OBJ_BL] + 6'd1;
                end
                if (rdel_reg[spvg_pkg::OBJ_BL] != 0)
                begin
                    if (rdel_reg[spvg_pkg::OBJ_BL] > 3'd3 || clk5[spvg_pkg::OBJ_BL])
                        rdel_next[spvg_pkg::OBJ_BL] = rdel_reg[spvg_pkg::OBJ_BL] - 3'd1;
                    if (rdel_next[spvg_pkg::OBJ_BL] == 0)
                        pos_next[spvg_pkg::OBJ_BL] = spvg_pkg::VISIBLE - 8'd1;
                end
                if (clk5[spvg_pkg::OBJ_BL])
                begin
                    pos_next[spvg_pkg::OBJ_BL] = pos_next[spvg_pkg::OBJ_BL] + 8'd1;
                    if (pos_next[spvg_pkg::OBJ_BL] >= spvg_pkg::VISIBLE)
                    begin
                        en = oflags_reg[spvg_pkg::OF_VDELBL] ? oflags_reg[spvg_pkg::OF_ENABL_OLD]
                                                            : oflags_reg[spvg_pkg::OF_ENABL_NEW];
                        opix_next[spvg_pkg::OBJ_BL] = en;
                        wid_next[spvg_pkg::OBJ_BL] = 6'd1;
                        pos_next[spvg_pkg::OBJ_BL] = '0;
                    end
                end

                // Missiles.
                for (int i = spvg_pkg::OBJ_M0; i <= spvg_pkg::OBJ_M1; i++)
                begin
                    sz = 6'd1 << mode_reg[i-1][5:4];
                    if (clk5[i] && wid_reg[i] != 0)
                    begin
                        if (wid_reg[i] == sz)
                        begin
                            opix_next[i] = 1'b0; wid_next[i] = '0;
                        end
                        else wid_next[i] = wid_reg[i] + 6'd1;
                    end
                    if (rdel_reg[i] != 0)
                    begin
                        if (rdel_reg[i] > 3'd4 || clk5[i]) rdel_next[i] = rdel_reg[i] - 3'd1;
                        if (rdel_next[i] == 0) pos_next[i] = '0;
                    end
                    if (clk5[i])
                    begin
                        pos_next[i] = pos_next[i] + 8'd1;
                        if (pos_next[i] >= spvg_pkg::VISIBLE) pos_next[i] = '0;
                        if (spvg_pkg::copy_start(pos_next[i], mode_reg[i-1]))
                        begin
                            opix_next[i] = oflags_reg[spvg_pkg::OF_ENAM0+i-spvg_pkg::OBJ_M0]
                                && !oflags_reg[spvg_pkg::OF_RESMP0+i-spvg_pkg::OBJ_M0];
                            wid_next[i] = 6'd1;
                        end
                    end
                end

                // Players.
                for (int i = spvg_pkg::OBJ_P0; i <= spvg_pkg::OBJ_P1; i++)
                begin
                    if (clk5[i] && wid_reg[i] != 0)
                    begin
                        c = oflags_reg[spvg_pkg::OF_VDELP0+i] ? grp_reg[2*i+1] : grp_reg[2*i];
                        cnt = wid_reg[i];
                        mode = mode_reg[1+i][2:0];
                        wide = (mode == 3'd5) || (mode == 3'd7);
                        lim = (mode == 3'd5) ? 6'd17 : ((mode == 3'd7) ? 6'd33 : 6'd8);
                        refl = oflags_reg[spvg_pkg::OF_REFP0+i];
                        shown = 1'b0;
                        if (cnt > lim) wid_next[i] = '0;
                        else
                        begin
                            if (wide)
                            begin
                                if (cnt >= 6'd2)
                                begin
                                    sx = 8'(cnt - 6'd2) >> ((mode == 3'd5) ? 1 : 2);
                                    n = refl ? sx[2:0] : 3'd7 - sx[2:0];
                                    shown = c[n];
                                end
                            end
                            else
                            begin
                                n = refl ? 3'(cnt - 6'd1) : 3'(6'd8 - cnt);
                                shown = c[n];
                            end
                            wid_next[i] = cnt + 6'd1;
                        end
                        opix_next[i] = shown;
                    end
                    if (rdel_reg[i] != 0)
                    begin
                        if (rdel_reg[i] > 3'd4 || clk5[i]) rdel_next[i] = rdel_reg[i] - 3'd1;
                        if (rdel_next[i] == 0) pos_next[i] = '0;
                    end
                end
                for (int i = spvg_pkg::OBJ_P0; i <= spvg_pkg::OBJ_P1; i++)
                begin
                    if (clk5[i])
                    begin
                        pos_next[i] = pos_next[i] + 8'd1;
                        if (pos_next[i] >= spvg_pkg::VISIBLE) pos_next[i] = '0;
                        if (spvg_pkg::copy_start(pos_next[i], mode_reg[1+i])) wid_next[i] = 6'd1;
                        if (oflags_reg[spvg_pkg::OF_RESMP0+i])
                        begin
                            mode = mode_reg[1+i][2:0];
                            at = (mode == 3'd5) ? 8'd8 : ((mode == 3'd7) ? 8'd12 : 8'd5);
                            if (pos_next[i] == at) pos_next[spvg_pkg::OBJ_M0+i] = '0;
                        end
                    end
                end

                if (!vblank_bits_reg[1])
                    for (int k = 0; k < 15; k++)
                        if (opix_next[spvg_pkg::PAIR_A[k]] && opix_next[spvg_pkg::PAIR_B[k]])
                            coll_next[k] = 1'b1;

                if (hc >= spvg_pkg::HBLANK_END && hc < spvg_pkg::LINE_CLOCKS)
                begin
                    sx = hc - spvg_pkg::HBLANK_END;
                    out_next.pixel_valid = 1'b1;
                    out_next.pixel_column = sx;
                    pfon = opix_next[spvg_pkg::PIX_PF] || opix_next[spvg_pkg::OBJ_BL];
                    c = color_reg[3];
                    if (pfon)
                        c = mode_reg[0][1] ? ((sx >= 8'd80) ? color_reg[1] : color_reg[0])
                                           : color_reg[2];
                    if (opix_next[spvg_pkg::OBJ_P1] || opix_next[spvg_pkg::OBJ_M1])
                        c = color_reg[1];
                    if (opix_next[spvg_pkg::OBJ_P0] || opix_next[spvg_pkg::OBJ_M0])
                        c = color_reg[0];
                    if (mode_reg[0][2] && pfon) c = color_reg[2];
                    if (blank_flags_reg[0] || vblank_bits_reg[1]) c = '0;
                    out_next.pixel_color = c;
                end

                hc = hc + 8'd1;
                if ((!blank_flags_reg[1] && hc == spvg_pkg::HBLANK_END)
                    || (blank_flags_reg[1] && hc == spvg_pkg::LONG_HBLANK_END))
                    blank_flags_next[0] = 1'b0;
                else if (hc >= spvg_pkg::LINE_CLOCKS)
                begin
                    hc = '0;
                    blank_flags_next[0] = 1'b1;
                    blank_flags_next[1] = 1'b0;
                    out_next.line_end = 1'b1;
                    out_next.line_shown = !vblank_bits_reg[1];
                end
                else if (blank_flags_reg[3] && hc == spvg_pkg::RELEASE_CLOCK)
                begin
                    blank_flags_next[3] = 1'b0;
                    out_next.cpu_release = 1'b1;
                end
                line_clock_next = hc;

                if (mseq_reg != 0)
                begin
                    mseq_next = mseq_reg + 7'd1;
                    if (mseq_next == 7'd6) blank_flags_next[1] = 1'b1;
                    else if (mseq_next > 7'd72) mseq_next = '0;
                    else if (mseq_next >= 7'd12)
                    begin
                        xc = (mseq_next == 7'd12) ? 5'h1f : xclk_reg;
                        if (mseq_next[1:0] == 2'b00)
                        begin
                            r0 = 8'(mseq_next - 7'd12) >> 2;
                            for (int i = 0; i < 5; i++)
                                if ({4'd0, motion_reg[i]} == r0) xc[i] = 1'b0;
                        end
                        xclk_next = xc;
                    end
                end
            end
            spvg_pkg::OP_WRITE:
            begin
                unique case (it.address)
                    spvg_pkg::A_VSYNC:
                    begin
                        out_next.frame_start = it.data[1] && !blank_flags_reg[2];
                        blank_flags_next[2] = it.data[1];
                    end
                    spvg_pkg::A_VBLANK:
                    begin
                        vblank_bits_next = it.data & 8'hc2;
                        if (!it.data[6]) ilatch_next = 2'b11;
                    end
                    spvg_pkg::A_WSYNC:
                    begin
                        out_next.cpu_hold = 1'b1;
                        blank_flags_next[3] = 1'b1;
                    end
                    spvg_pkg::A_RSYNC:
                    begin
                        line_clock_next = '0;
                        blank_flags_next[0] = 1'b1;
                    end
                    spvg_pkg::A_NUSIZ0: mode_next[1] = it.data & 8'h37;
                    spvg_pkg::A_NUSIZ1: mode_next[2] = it.data & 8'h37;
                    spvg_pkg::A_COLUP0: color_next[0] = it.data & 8'hfe;
                    spvg_pkg::A_COLUP1: color_next[1] = it.data & 8'hfe;
                    spvg_pkg::A_COLUPF: color_next[2] = it.data & 8'hfe;
                    spvg_pkg::A_COLUBK: color_next[3] = it.data & 8'hfe;
                    spvg_pkg::A_CTRLPF: mode_next[0] = it.data & 8'h37;
                    spvg_pkg::A_REFP0: oflags_next[spvg_pkg::OF_REFP0] = it.data[3];
                    spvg_pkg::A_REFP1: oflags_next[spvg_pkg::OF_REFP0+1] = it.data[3];
                    spvg_pkg::A_PF0: pf_bits_next[0] = it.data & 8'hf0;
                    spvg_pkg::A_PF1: pf_bits_next[1] = it.data;
                    spvg_pkg::A_PF2: pf_bits_next[2] = it.data;
                    spvg_pkg::A_RESP0: rdel_next[spvg_pkg::OBJ_P0] = 3'd6;
                    spvg_pkg::A_RESP1: rdel_next[spvg_pkg::OBJ_P1] = 3'd6;
                    spvg_pkg::A_RESM0: rdel_next[spvg_pkg::OBJ_M0] = 3'd6;
                    spvg_pkg::A_RESM1: rdel_next[spvg_pkg::OBJ_M1] = 3'd6;
                    spvg_pkg::A_RESBL: rdel_next[spvg_pkg::OBJ_BL] = 3'd5;
                    spvg_pkg::A_GRP0:
                    begin
                        grp_next[0] = it.data;
                        grp_next[3] = grp_reg[2];
                    end
                    spvg_pkg::A_GRP1:
                    begin
                        grp_next[2] = it.data;
                        grp_next[1] = grp_reg[0];
                        oflags_next[spvg_pkg::OF_ENABL_OLD] = oflags_reg[spvg_pkg::OF_ENABL_NEW];
                    end
                    spvg_pkg::A_ENAM0: oflags_next[spvg_pkg::OF_ENAM0] = it.data[1];
                    spvg_pkg::A_ENAM1: oflags_next[spvg_pkg::OF_ENAM0+1] = it.data[1];
                    spvg_pkg::A_ENABL: oflags_next[spvg_pkg::OF_ENABL_NEW] = it.data[1];
                    spvg_pkg::A_HMP0: motion_next[0] = it.data[7:4] ^ 4'd8;
                    spvg_pkg::A_HMP1: motion_next[1] = it.data[7:4] ^ 4'd8;
                    spvg_pkg::A_HMM0: motion_next[2] = it.data[7:4] ^ 4'd8;
                    spvg_pkg::A_HMM1: motion_next[3] = it.data[7:4] ^ 4'd8;
                    spvg_pkg::A_HMBL: motion_next[4] = it.data[7:4] ^ 4'd8;
                    spvg_pkg::A_VDELP0: oflags_next[spvg_pkg::OF_VDELP0] = it.data[0];
                    spvg_pkg::A_VDELP1: oflags_next[spvg_pkg::OF_VDELP0+1] = it.data[0];
                    spvg_pkg::A_VDELBL: oflags_next[spvg_pkg::OF_VDELBL] = it.data[0];
                    spvg_pkg::A_RESMP0: oflags_next[spvg_pkg::OF_RESMP0] = it.data[1];
                    spvg_pkg::A_RESMP1: oflags_next[spvg_pkg::OF_RESMP0+1] = it.data[1];
                    spvg_pkg::A_HMOVE: mseq_next = 7'd1 + {5'd0, 2'(line_clock_reg + 8'd1)};
                    spvg_pkg::A_HMCLR: for (int i = 0; i < 5; i++) motion_next[i] = 4'd8;
                    spvg_pkg::A_CXCLR: coll_next = '0;
                    default: ;
                endcase
            end
            spvg_pkg::OP_READ:
            begin
                rr = 3'(it.address[3:0]);
                c = 8'hff;
                if (it.address[3:0] <= 4'd5)
                    c = {coll_reg[{rr, 1'b0}], coll_reg[{rr, 1'b1}], 6'd0};
                else if (it.address[3:0] == 4'd6) c = {coll_reg[12], 7'd0};
                else if (it.address[3:0] == 4'd7) c = {coll_reg[13], coll_reg[14], 6'd0};
                else if (it.address[3:0] <= 4'd11)
                    c = {pins_reg[{1'b0, it.address[1:0]}] && !vblank_bits_reg[7], 7'd0};
                else if (it.address[3:0] <= 4'd13)
                    c = {pins_reg[{2'b10, it.address[0]}] && ilatch_reg[it.address[0]], 7'd0};
                out_next.read_data = c;
            end
            spvg_pkg::OP_PINS:
            begin
                pins_next = (pins_reg & ~it.pins_cleared) | it.pins_set;
                if (vblank_bits_reg[6]) ilatch_next = ilatch_reg & ~it.pins_cleared[5:4];
            end
            default: ;
        endcase
        out_next.pots_dumped = vblank_bits_next[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_clock_reg <= '0;
            blank_flags_reg <= 4'b0001;
            vblank_bits_reg <= '0;
            oflags_reg <= '0;
            xclk_reg <= '0;
            mseq_reg <= '0;
            opix_reg <= '0;
            coll_reg <= '0;
            pins_reg <= 6'h3f;
            ilatch_reg <= 2'b11;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pf_bits_reg[i] <= '0; pf_shift_reg[i] <= '0; mode_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                color_reg[i] <= '0; grp_reg[i] <= '0;
            end
            for (int i = 0; i < 5; i++)
            begin
                motion_reg[i] <= '0; pos_reg[i] <= '0; wid_reg[i] <= '0; rdel_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                line_clock_reg <= line_clock_next;
                blank_flags_reg <= blank_flags_next;
                vblank_bits_reg <= vblank_bits_next;
                pf_bits_reg <= pf_bits_next;
                pf_shift_reg <= pf_shift_next;
                mode_reg <= mode_next;
                color_reg <= color_next;
                grp_reg <= grp_next;
                oflags_reg <= oflags_next;
                motion_reg <= motion_next;
                pos_reg <= pos_next;
                wid_reg <= wid_next;
                rdel_reg <= rdel_next;
                xclk_reg <= xclk_next;
                mseq_reg <= mseq_next;
                opix_reg <= opix_next;
                coll_reg <= coll_next;
                pins_reg <= pins_next;
                ilatch_reg <= ilatch_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) out_reg <= out_next;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 4000;

    localparam int BF_HBLANK = 1;
    localparam int BF_LONG = 2;
    localparam int BF_VSYNC = 4;
    localparam int BF_WSYNC = 8;

    localparam logic [5:0] A_LAST = 6'h3f;

    logic clk;
    logic rst_n;

    spvg_stream_if #(.payload_t(spvg_pkg::in_item_t)) in_ch ();
    spvg_stream_if #(.payload_t(spvg_pkg::out_item_t)) out_ch ();

    sprite_playfield_video_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    spvg_pkg::in_item_t  pending_items [$];
    spvg_pkg::out_item_t expected_results [$];
    int n_total;
    int n_sent;
    int n_errors;
    int idle_cycles;

    int hclock;
    int blank;
    int vblank;
    int pf_bits [3];
    int pf_shift [3];
    int modes [3];
    int colors [4];
    int graphics [4];
    int flags;
    int motion [5];
    int pos_ctr [5];
    int wid_ctr [5];
    int res_delay [5];
    int extra_clk;
    int hm_seq;
    int obj_pix;
    int collisions;
    int pins;
    int pin_latches;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit bit_at(int v, int b);
        return ((v >> b) & 1) != 0;
    endfunction

    function automatic int with_bit(int v, int b, bit on);
        return on ? (v | (1 << b)) : (v & ~(1 << b));
    endfunction

    function automatic bit delay_done(int i, int free_above, bit ck);
        if (res_delay[i] == 0)
            return 1'b0;
        if (res_delay[i] > free_above || ck)
            res_delay[i]--;
        return res_delay[i] == 0;
    endfunction

    function automatic bit player_bit(int i, int grp, int nus, bit refl);
        int cnt;
        int mode;
        int lim;
        int n;
        bit shown;
        cnt = wid_ctr[i];
        mode = nus & 7;
        lim = (mode == 5) ? 17 : ((mode == 7) ? 33 : 8);
        if (cnt > lim)
        begin
            wid_ctr[i] = 0;
            return 1'b0;
        end
        if (mode == 5 || mode == 7)
        begin
            if (cnt < 2)
                shown = 1'b0;
            else
            begin
                n = (cnt - 2) >> ((mode == 5) ? 1 : 2);
                if (!refl)
                    n = 7 - n;
                shown = ((grp >> (n & 7)) & 1) != 0;
            end
        end
        else
        begin
            n = refl ? cnt - 1 : 8 - cnt;
            shown = ((grp >> (n & 7)) & 1) != 0;
        end
        wid_ctr[i] = (cnt + 1) & 'h3f;
        return shown;
    endfunction

    function automatic void step_playfield(int hc);
        bit refl;
        int s0;
        int s1;
        int s2;
        refl = (modes[0] & 1) != 0;
        if (hc == spvg_pkg::HBLANK_END || (hc == spvg_pkg::LINE_CENTER && !refl))
            pf_shift = '{'h10, 0, 0};
        else if (hc == spvg_pkg::LINE_CENTER)
            pf_shift = '{0, 0, 'h80};
        obj_pix = with_bit(obj_pix, spvg_pkg::PIX_PF, ((pf_bits[0] & pf_shift[0]) |
            (pf_bits[1] & pf_shift[1]) | (pf_bits[2] & pf_shift[2])) != 0);
        if ((hc & 3) == 3)
        begin
            s0 = pf_shift[0];
            s1 = pf_shift[1];
            s2 = pf_shift[2];
            if (refl && hc >= spvg_pkg::LINE_CENTER)
            begin
                pf_shift[0] = ((s0 >> 1) | (s1 & 'h80)) & 'hff;
                pf_shift[1] = ((s1 << 1) | (s2 & 1)) & 'hff;
                pf_shift[2] = (s2 >> 1) & 'hff;
            end
            else
            begin
                pf_shift[2] = ((s2 << 1) | (s1 & 1)) & 'hff;
                pf_shift[1] = ((s1 >> 1) | (s0 & 'h80)) & 'hff;
                pf_shift[0] = (s0 << 1) & 'hff;
            end
        end
    endfunction

    function automatic bit starts_copy(int ctr, int nus);
        int n;
        n = nus & 7;
        if (ctr == 0)
            return 1'b1;
        if (ctr == 16)
            return n == 1 || n == 3;
        if (ctr == 32)
            return n == 2 || n == 3 || n == 6;
        if (ctr == 64)
            return n == 4 || n == 6;
        return 1'b0;
    endfunction

    function automatic void step_objects(bit ck [5]);
        int sz;
        int nus;
        int grp;
        int mode;
        int at;
        bit en;
        sz = 1 << ((modes[0] >> 4) & 3);
        if (ck[spvg_pkg::OBJ_BL] && wid_ctr[spvg_pkg::OBJ_BL] > 0)
        begin
            if (wid_ctr[spvg_pkg::OBJ_BL] == sz)
            begin
                obj_pix = with_bit(obj_pix, spvg_pkg::OBJ_BL, 1'b0);
                wid_ctr[spvg_pkg::OBJ_BL] = 0;
            end
            else
                wid_ctr[spvg_pkg::OBJ_BL] = (wid_ctr[spvg_pkg::OBJ_BL] + 1) & 'h3f;
        end
        if (delay_done(spvg_pkg::OBJ_BL, 3, ck[spvg_pkg::OBJ_BL]))
            pos_ctr[spvg_pkg::OBJ_BL] = spvg_pkg::VISIBLE - 1;
        if (ck[spvg_pkg::OBJ_BL])
        begin
            pos_ctr[spvg_pkg::OBJ_BL]++;
            if (pos_ctr[spvg_pkg::OBJ_BL] >= spvg_pkg::VISIBLE)
            begin
                en = bit_at(flags, spvg_pkg::OF_VDELBL) ? bit_at(flags, spvg_pkg::OF_ENABL_OLD)
                    : bit_at(flags, spvg_pkg::OF_ENABL_NEW);
                obj_pix = with_bit(obj_pix, spvg_pkg::OBJ_BL, en);
                wid_ctr[spvg_pkg::OBJ_BL] = 1;
                pos_ctr[spvg_pkg::OBJ_BL] = 0;
            end
        end
        for (int i = spvg_pkg::OBJ_M0; i <= spvg_pkg::OBJ_M1; i++)
        begin
            sz = 1 << ((modes[i - 1] >> 4) & 3);
            if (ck[i] && wid_ctr[i] > 0)
            begin
                if (wid_ctr[i] == sz)
                begin
                    obj_pix = with_bit(obj_pix, i, 1'b0);
                    wid_ctr[i] = 0;
                end
                else
                    wid_ctr[i] = (wid_ctr[i] + 1) & 'h3f;
            end
        end
        for (int i = spvg_pkg::OBJ_M0; i <= spvg_pkg::OBJ_M1; i++)
            if (delay_done(i, 4, ck[i]))
                pos_ctr[i] = 0;
        for (int i = spvg_pkg::OBJ_M0; i <= spvg_pkg::OBJ_M1; i++)
        begin
            if (ck[i])
            begin
                pos_ctr[i]++;
                if (pos_ctr[i] >= spvg_pkg::VISIBLE)
                    pos_ctr[i] = 0;
                if (starts_copy(pos_ctr[i], modes[i - 1]))
                begin
                    obj_pix = with_bit(obj_pix, i,
                        bit_at(flags, spvg_pkg::OF_ENAM0 + i - spvg_pkg::OBJ_M0)
                        && !bit_at(flags, spvg_pkg::OF_RESMP0 + i - spvg_pkg::OBJ_M0));
                    wid_ctr[i] = 1;
                end
            end
        end
        for (int i = spvg_pkg::OBJ_P0; i <= spvg_pkg::OBJ_P1; i++)
        begin
            if (ck[i] && wid_ctr[i] > 0)
            begin
                grp = bit_at(flags, spvg_pkg::OF_VDELP0 + i) ? graphics[2 * i + 1]
                    : graphics[2 * i];
                obj_pix = with_bit(obj_pix, i,
                    player_bit(i, grp, modes[1 + i], bit_at(flags, spvg_pkg::OF_REFP0 + i)));
            end
        end
        for (int i = spvg_pkg::OBJ_P0; i <= spvg_pkg::OBJ_P1; i++)
            if (delay_done(i, 4, ck[i]))
                pos_ctr[i] = 0;
        for (int i = spvg_pkg::OBJ_P0; i <= spvg_pkg::OBJ_P1; i++)
        begin
            if (ck[i])
            begin
                nus = modes[1 + i];
                pos_ctr[i]++;
                if (pos_ctr[i] >= spvg_pkg::VISIBLE)
                    pos_ctr[i] = 0;
                if (starts_copy(pos_ctr[i], nus))
                    wid_ctr[i] = 1;
                if (bit_at(flags, spvg_pkg::OF_RESMP0 + i))
                begin
                    mode = nus & 7;
                    at = (mode == 5) ? 8 : ((mode == 7) ? 12 : 5);
                    if (pos_ctr[i] == at)
                        pos_ctr[spvg_pkg::OBJ_M0 + i] = 0;
                end
            end
        end
    endfunction

    function automatic int color_at(int x);
        bit pf;
        int c;
        pf = bit_at(obj_pix, spvg_pkg::PIX_PF) || bit_at(obj_pix, spvg_pkg::OBJ_BL);
        c = colors[3];
        if ((blank & BF_HBLANK) != 0 || (vblank & 2) != 0)
            return 0;
        if (pf)
            c = ((modes[0] & 2) != 0) ? ((x >= spvg_pkg::VISIBLE / 2) ? colors[1] : colors[0])
                : colors[2];
        if (bit_at(obj_pix, spvg_pkg::OBJ_P1) || bit_at(obj_pix, spvg_pkg::OBJ_M1))
            c = colors[1];
        if (bit_at(obj_pix, spvg_pkg::OBJ_P0) || bit_at(obj_pix, spvg_pkg::OBJ_M0))
            c = colors[0];
        if ((modes[0] & 4) != 0 && pf)
            c = colors[2];
        return c;
    endfunction

    function automatic void step_motion();
        hm_seq++;
        if (hm_seq == 6)
            blank |= BF_LONG;
        else if (hm_seq > 72)
            hm_seq = 0;
        else if (hm_seq >= 12)
        begin
            if (hm_seq == 12)
                extra_clk = 'h1f;
            if ((hm_seq & 3) == 0)
                for (int i = 0; i < 5; i++)
                    if (motion[i] == ((hm_seq - 12) >> 2))
                        extra_clk &= ~(1 << i);
        end
    endfunction

    function automatic void color_clock(ref spvg_pkg::out_item_t r);
        int hc;
        bit ck [5];
        hc = hclock;
        step_playfield(hc);
        for (int i = 0; i < 5; i++)
            ck[i] = (blank & BF_HBLANK) == 0 || (bit_at(extra_clk, i) && (hm_seq & 3) == 0);
        step_objects(ck);
        if ((vblank & 2) == 0)
            for (int k = 0; k < 15; k++)
                if (bit_at(obj_pix, spvg_pkg::PAIR_A[k]) && bit_at(obj_pix, spvg_pkg::PAIR_B[k]))
                    collisions |= 1 << k;
        if (hc >= spvg_pkg::HBLANK_END && hc < spvg_pkg::LINE_CLOCKS)
        begin
            r.pixel_valid = 1'b1;
            r.pixel_column = 8'(hc - spvg_pkg::HBLANK_END);
            r.pixel_color = 8'(color_at(hc - spvg_pkg::HBLANK_END));
        end
        hc++;
        if (((blank & BF_LONG) == 0 && hc == spvg_pkg::HBLANK_END) ||
            ((blank & BF_LONG) != 0 && hc == spvg_pkg::LONG_HBLANK_END))
            blank &= ~BF_HBLANK;
        else if (hc >= spvg_pkg::LINE_CLOCKS)
        begin
            hc = 0;
            blank = (blank | BF_HBLANK) & ~BF_LONG;
            r.line_end = 1'b1;
            r.line_shown = (vblank & 2) == 0;
        end
        else if ((blank & BF_WSYNC) != 0 && hc == spvg_pkg::RELEASE_CLOCK)
        begin
            blank &= ~BF_WSYNC;
            r.cpu_release = 1'b1;
        end
        hclock = hc;
        if (hm_seq > 0)
            step_motion();
    endfunction

    function automatic void register_write(int a, int d, ref spvg_pkg::out_item_t r);
        if (a == spvg_pkg::A_VSYNC)
        begin
            if ((d & 2) != 0 && (blank & BF_VSYNC) == 0)
                r.frame_start = 1'b1;
            blank = ((d & 2) != 0) ? (blank | BF_VSYNC) : (blank & ~BF_VSYNC);
        end
        else if (a == spvg_pkg::A_VBLANK)
        begin
            vblank = d & 'hc2;
            if ((vblank & 'h40) == 0)
                pin_latches = 3;
        end
        else if (a == spvg_pkg::A_WSYNC)
        begin
            r.cpu_hold = 1'b1;
            blank |= BF_WSYNC;
        end
        else if (a == spvg_pkg::A_RSYNC)
        begin
            hclock = 0;
            blank |= BF_HBLANK;
        end
        else if (a == spvg_pkg::A_NUSIZ0 || a == spvg_pkg::A_NUSIZ1)
            modes[a - 3] = d & 'h37;
        else if (a >= spvg_pkg::A_COLUP0 && a <= spvg_pkg::A_COLUBK)
            colors[a - spvg_pkg::A_COLUP0] = d & 'hfe;
        else if (a == spvg_pkg::A_CTRLPF)
            modes[0] = d & 'h37;
        else if (a == spvg_pkg::A_REFP0 || a == spvg_pkg::A_REFP1)
            flags = with_bit(flags, spvg_pkg::OF_REFP0 + a - spvg_pkg::A_REFP0, (d & 8) != 0);
        else if (a == spvg_pkg::A_PF0)
            pf_bits[0] = d & 'hf0;
        else if (a == spvg_pkg::A_PF1 || a == spvg_pkg::A_PF2)
            pf_bits[a - spvg_pkg::A_PF0] = d;
        else if (a >= spvg_pkg::A_RESP0 && a <= spvg_pkg::A_RESM1)
            res_delay[a - spvg_pkg::A_RESP0] = 6;
        else if (a == spvg_pkg::A_RESBL)
            res_delay[spvg_pkg::OBJ_BL] = 5;
        else if (a == spvg_pkg::A_GRP0)
        begin
            graphics[0] = d;
            graphics[3] = graphics[2];
        end
        else if (a == spvg_pkg::A_GRP1)
        begin
            graphics[2] = d;
            graphics[1] = graphics[0];
            flags = with_bit(flags, spvg_pkg::OF_ENABL_OLD, bit_at(flags, spvg_pkg::OF_ENABL_NEW));
        end
        else if (a == spvg_pkg::A_ENAM0 || a == spvg_pkg::A_ENAM1)
            flags = with_bit(flags, spvg_pkg::OF_ENAM0 + a - spvg_pkg::A_ENAM0, (d & 2) != 0);
        else if (a == spvg_pkg::A_ENABL)
            flags = with_bit(flags, spvg_pkg::OF_ENABL_NEW, (d & 2) != 0);
        else if (a >= spvg_pkg::A_HMP0 && a <= spvg_pkg::A_HMBL)
            motion[a - spvg_pkg::A_HMP0] = ((d >> 4) ^ 8) & 'hf;
        else if (a >= spvg_pkg::A_VDELP0 && a <= spvg_pkg::A_VDELBL)
            flags = with_bit(flags, spvg_pkg::OF_VDELP0 + a - spvg_pkg::A_VDELP0, (d & 1) != 0);
        else if (a == spvg_pkg::A_RESMP0 || a == spvg_pkg::A_RESMP1)
            flags = with_bit(flags, spvg_pkg::OF_RESMP0 + a - spvg_pkg::A_RESMP0, (d & 2) != 0);
        else if (a == spvg_pkg::A_HMOVE)
            hm_seq = 1 + ((hclock + 1) & 3);
        else if (a == spvg_pkg::A_HMCLR)
            motion = '{8, 8, 8, 8, 8};
        else if (a == spvg_pkg::A_CXCLR)
            collisions = 0;
    endfunction

    function automatic int register_read(int a);
        int r;
        r = a & 'hf;
        if (r <= 5)
            return (((collisions >> (2 * r)) & 1) << 7) | (((collisions >> (2 * r + 1)) & 1) << 6);
        if (r == 6)
            return ((collisions >> 12) & 1) << 7;
        if (r == 7)
            return (((collisions >> 13) & 1) << 7) | (((collisions >> 14) & 1) << 6);
        if (r <= 11)
            return (bit_at(pins, r - 8) && (vblank & 'h80) == 0) ? 'h80 : 0;
        if (r <= 13)
            return (bit_at(pins, r - 8) && bit_at(pin_latches, r - 12)) ? 'h80 : 0;
        return 'hff;
    endfunction

    function automatic spvg_pkg::out_item_t predict_video_step(spvg_pkg::in_item_t it);
        spvg_pkg::out_item_t r;
        r = '0;
        case (it.operation)
            spvg_pkg::OP_TICK: color_clock(r);
            spvg_pkg::OP_WRITE: register_write(it.address, it.data, r);
            spvg_pkg::OP_READ: r.read_data = 8'(register_read(it.address));
            default:
            begin
                pins = ((pins & ~int'(it.pins_cleared)) | it.pins_set) & 'h3f;
                if ((vblank & 'h40) != 0)
                    pin_latches &= ~(int'(it.pins_cleared) >> 4) & 3;
            end
        endcase
        r.pots_dumped = (vblank & 'h80) != 0;
        return r;
    endfunction

    function automatic void reset_video_model();
        hclock = 0;
        blank = BF_HBLANK;
        vblank = 0;
        pf_bits = '{0, 0, 0};
        pf_shift = '{0, 0, 0};
        modes = '{0, 0, 0};
        colors = '{0, 0, 0, 0};
        graphics = '{0, 0, 0, 0};
        flags = 0;
        motion = '{0, 0, 0, 0, 0};
        pos_ctr = '{0, 0, 0, 0, 0};
        wid_ctr = '{0, 0, 0, 0, 0};
        res_delay = '{0, 0, 0, 0, 0};
        extra_clk = 0;
        hm_seq = 0;
        obj_pix = 0;
        collisions = 0;
        pins = 'h3f;
        pin_latches = 3;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        n_errors++;
    endtask

    task automatic add_item(logic [1:0] op, logic [5:0] a, logic [7:0] d,
        logic [5:0] ps, logic [5:0] pc);
        spvg_pkg::in_item_t it;
        it.operation = op;
        it.address = a;
        it.data = d;
        it.pins_set = ps;
        it.pins_cleared = pc;
        pending_items.push_back(it);
    endtask

    function automatic int sender_idle_pct();
        if (n_sent < n_total / 3)
            return 25;
        if (n_sent < 2 * n_total / 3)
            return 82;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_sent < n_total / 3)
            return 82;
        if (n_sent < 2 * n_total / 3)
            return 25;
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.payload <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                void'(pending_items.pop_front());
                n_sent++;
            end
            if (in_ch.valid && !in_ch.ready)
                in_ch.valid <= 1'b1;
            else if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct())
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_items[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= $urandom_range(99) >= receiver_idle_pct();
    end

    always @(posedge clk)
    begin
        spvg_pkg::out_item_t want;
        spvg_pkg::out_item_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.pixel_valid !== want.pixel_valid)
                        report_mismatch("pixel_valid", got.pixel_valid, want.pixel_valid);
                    if (got.pixel_column !== want.pixel_column)
                        report_mismatch("pixel_column", got.pixel_column, want.pixel_column);
                    if (got.pixel_color !== want.pixel_color)
                        report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
                    if (got.line_end !== want.line_end)
                        report_mismatch("line_end", got.line_end, want.line_end);
                    if (got.line_shown !== want.line_shown)
                        report_mismatch("line_shown", got.line_shown, want.line_shown);
                    if (got.frame_start !== want.frame_start)
                        report_mismatch("frame_start", got.frame_start, want.frame_start);
                    if (got.cpu_hold !== want.cpu_hold)
                        report_mismatch("cpu_hold", got.cpu_hold, want.cpu_hold);
                    if (got.cpu_release !== want.cpu_release)
                        report_mismatch("cpu_release", got.cpu_release, want.cpu_release);
                    if (got.pots_dumped !== want.pots_dumped)
                        report_mismatch("pots_dumped", got.pots_dumped, want.pots_dumped);
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_video_step(in_ch.payload));
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int r;
        logic [5:0] a;
        reset_video_model();

        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_VSYNC, 8'h02, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_VSYNC, 8'hff, 6'h3f, 6'h3f);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_VSYNC, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_COLUP0, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_PF1, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_CTRLPF, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_NUSIZ0, 8'h07, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_GRP0, 8'ha5, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_HMP0, 8'h70, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_HMOVE, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, 6'h2d, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, A_LAST, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, 6'h15, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_VBLANK, 8'hc0, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_PINS, 6'h00, 8'h00, 6'h00, 6'h3f);
        add_item(spvg_pkg::OP_READ, 6'h0c, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_PINS, 6'h00, 8'h00, 6'h3f, 6'h00);
        add_item(spvg_pkg::OP_READ, 6'h3d, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_READ, 6'h0e, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_READ, A_LAST, 8'hff, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_VBLANK, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_WRITE, spvg_pkg::A_WSYNC, 8'h00, 6'h00, 6'h00);
        add_item(spvg_pkg::OP_TICK, 6'h3f, 8'hff, 6'h3f, 6'h3f);
        add_item(spvg_pkg::OP_TICK, 6'h00, 8'h00, 6'h00, 6'h00);

        for (int n = 0; n < 1400; n++)
        begin
            r = $urandom_range(99);
            if (r < 78)
                add_item(spvg_pkg::OP_TICK, 6'($urandom), 8'($urandom), 6'($urandom),
                    6'($urandom));
            else if (r < 92)
            begin
                a = ($urandom_range(9) == 0) ? 6'($urandom)
                    : 6'($urandom_range(spvg_pkg::A_CXCLR));
                if (a == spvg_pkg::A_VBLANK && $urandom_range(3) != 0)
                    add_item(spvg_pkg::OP_WRITE, a, 8'($urandom) & 8'h7d, 6'h00, 6'h00);
                else
                    add_item(spvg_pkg::OP_WRITE, a, 8'($urandom), 6'($urandom), 6'($urandom));
            end
            else if (r < 96)
                add_item(spvg_pkg::OP_READ, 6'($urandom), 8'($urandom), 6'($urandom),
                    6'($urandom));
            else
                add_item(spvg_pkg::OP_PINS, 6'($urandom), 8'($urandom), 6'($urandom),
                    6'($urandom));
        end
        n_total = pending_items.size();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/spvg_pkg.sv
rtl/core/spvg_stream_if.sv
rtl/core/sprite_playfield_video_generator.sv
dv/tb.sv
